>>> sv/first_fit_page_run_allocator_defines.svh
// assertion macros for the first fit page run allocator
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// condition must hold in the same cycle
`define FPA_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("fpa check failed");
// condition must hold in the next cycle
`define FPA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("fpa check failed");
`else
`define FPA_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define FPA_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

>>> sv/fpa_pkg.sv
// shared types and constants of the page run allocator
`default_nettype none
package fpa_pkg;

  // field and register widths
  localparam int REQ_W        = 9;
  localparam int ADDR_W       = 32;
  localparam int BASE_PAGE_W  = 20;
  localparam int PAGE_COUNT_W = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 20;

  // parameter defaults
  localparam int PAGES_DEF      = 256;
  localparam int PAGE_BYTES_DEF = 4096;

  // used map word geometry
  localparam int SCAN_BITS = 8;
  localparam int BIT_W     = $clog2(SCAN_BITS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'd1;

  // register reset values
  localparam logic [BASE_PAGE_W-1:0]  BASE_PAGE_RST  = '0;
  localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RST = 9'd256;

  // result status codes
  localparam logic STATUS_GRANT   = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  // outcome of examining one used map word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] hit;
    logic             past_end;
  } scan_res_t;

endpackage
`default_nettype wire

>>> sv/fpa_req_if.sv
// request channel: valid, ready and the requested page count
`default_nettype none
interface fpa_req_if;
  logic                       valid;
  logic                       ready;
  logic [fpa_pkg::REQ_W-1:0]  want_pages;

  modport source (output valid, output want_pages, input ready);
  modport sink   (input valid, input want_pages, output ready);
endinterface
`default_nettype wire

>>> sv/fpa_resp_if.sv
// response channel: valid, ready, granted address and status
`default_nettype none
interface fpa_resp_if;
  logic                        valid;
  logic                        ready;
  logic [fpa_pkg::ADDR_W-1:0]  phys_addr;
  logic                        status;

  modport source (output valid, output phys_addr, output status, input ready);
  modport sink   (input valid, input phys_addr, input status, output ready);
endinterface
`default_nettype wire

>>> sv/fpa_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/fpa_scan.sv
// run length tracking across one word of the used map
`default_nettype none
module fpa_scan #(
  parameter int AW = 5,
  parameter int LW = 9
) (
  input  wire logic [fpa_pkg::SCAN_BITS-1:0] data,
  input  wire logic [AW-1:0]                 word,
  input  wire logic [LW-1:0]                 run_in,
  input  wire logic [LW-1:0]                 want,
  input  wire logic [LW-1:0]                 limit,
  output      logic [LW-1:0]                 run_out,
  output      fpa_pkg::scan_res_t            res
);

  localparam int XW   = AW + fpa_pkg::BIT_W;
  localparam int CMPW = ((XW > LW) ? XW : LW) + 1;

  // walk the bits of the word, stopping at the first run long enough
  always_comb begin
    logic [XW-1:0] idx;
    idx      = '0;
    run_out  = run_in;
    res      = '0;
    for (int j = 0; j < fpa_pkg::SCAN_BITS; j++) begin
      idx = {word, fpa_pkg::BIT_W'(j)};
      if (!res.found && (CMPW'(idx) < CMPW'(limit))) begin
        if (data[j]) begin
          run_out = '0;
        end else begin
          run_out = LW'(run_out + 1'b1);
          if (run_out == want) begin
            res.found = 1'b1;
            res.hit   = fpa_pkg::BIT_W'(j);
          end
        end
      end
    end
    // last word that holds managed pages
    res.past_end = (CMPW'({word, {fpa_pkg::BIT_W{1'b1}}}) + 1'b1) >= CMPW'(limit);
  end

endmodule
`default_nettype wire

>>> sv/first_fit_page_run_allocator.sv
// top level of the first fit page run allocator, one request in flight at a time
// a request scans the used map word by word for a free run, then marks each word of the run;
// a zero or oversized request, or a scan that finds no run, goes straight to the result word
// the next request is taken only after the result of the last one has loaded
// reset is synchronous; a clearing pass over every word of the used map empties it
`default_nettype none
`include "first_fit_page_run_allocator_defines.svh"
module first_fit_page_run_allocator #(
  parameter int PAGES      = fpa_pkg::PAGES_DEF,
  parameter int PAGE_BYTES = fpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  fpa_req_if.sink                               req,
  fpa_resp_if.source                            resp
);

  localparam int WORDS = (PAGES + fpa_pkg::SCAN_BITS - 1) / fpa_pkg::SCAN_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW    = AW + fpa_pkg::BIT_W;
  localparam int CW    = $clog2(PAGES + 1);
  localparam int LW    = (CW > fpa_pkg::REQ_W) ? CW : fpa_pkg::REQ_W;
  localparam int CMPW  = ((XW > LW) ? XW : LW) + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [fpa_pkg::ADDR_W-1:0] PAGE_BYTES_C = fpa_pkg::ADDR_W'(PAGE_BYTES);

  // controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                         state;
  logic [fpa_pkg::BASE_PAGE_W-1:0]    base_page;
  logic [fpa_pkg::PAGE_COUNT_W-1:0]   page_count;
  logic [AW-1:0]                      ra;
  logic [AW-1:0]                      pw;
  logic                               rvalid;
  logic [LW-1:0]                      want;
  logic [LW-1:0]                      run;
  logic [XW-1:0]                      end_idx;
  logic [XW-1:0]                      start;
  logic                               fail;
  logic [fpa_pkg::ADDR_W-1:0]         phys;
  logic                               out_valid;
  logic [fpa_pkg::ADDR_W-1:0]         out_addr;
  logic                               out_status;

  logic [LW-1:0]                      limit;
  logic [LW-1:0]                      run_next;
  fpa_pkg::scan_res_t                 scan_res;
  logic [XW-1:0]                      start_next;
  logic [AW-1:0]                      start_word;
  logic [AW-1:0]                      end_word;
  logic [fpa_pkg::SCAN_BITS-1:0]      mark_mask;
  logic [fpa_pkg::ADDR_W-1:0]         prod;
  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [fpa_pkg::SCAN_BITS-1:0]      ram_wdata;
  logic [fpa_pkg::SCAN_BITS-1:0]      ram_rdata;

  // managed page count, saturated at the map size
  assign limit = (LW'(page_count) > LW'(PAGES)) ? LW'(PAGES) : LW'(page_count);

  // run start from its last page
  assign start_next = XW'(CMPW'(end_idx) + 1'b1 - CMPW'(want));
  assign start_word = start[XW-1:fpa_pkg::BIT_W];
  assign end_word   = end_idx[XW-1:fpa_pkg::BIT_W];

  // pages of the current word that fall inside the granted run
  always_comb begin
    logic [XW-1:0] idx;
    idx = '0;
    for (int j = 0; j < fpa_pkg::SCAN_BITS; j++) begin
      idx          = {pw, fpa_pkg::BIT_W'(j)};
      mark_mask[j] = (idx >= start) && (idx <= end_idx);
    end
  end

  // byte address of the run, wrapping at 32 bits
  assign prod = fpa_pkg::ADDR_W'((fpa_pkg::ADDR_W'(base_page) + fpa_pkg::ADDR_W'(start))
                                 * PAGE_BYTES_C);

  // used map write side: clearing pass or run marking
  assign ram_we    = (state == S_CLEAR) || ((state == S_MARK) && rvalid);
  assign ram_waddr = (state == S_CLEAR) ? ra : pw;
  assign ram_wdata = (state == S_CLEAR) ? '0 : (ram_rdata | mark_mask);

  fpa_ram #(
    .WIDTH (fpa_pkg::SCAN_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra),
    .rdata (ram_rdata)
  );

  fpa_scan #(
    .AW (AW),
    .LW (LW)
  ) u_scan (
    .data    (ram_rdata),
    .word    (pw),
    .run_in  (run),
    .want    (want),
    .limit   (limit),
    .run_out (run_next),
    .res     (scan_res)
  );

  // handshake outputs
  assign req.ready      = (state == S_IDLE);
  assign resp.valid     = out_valid;
  assign resp.phys_addr = out_addr;
  assign resp.status    = out_status;

  // controller, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      base_page  <= fpa_pkg::BASE_PAGE_RST;
      page_count <= fpa_pkg::PAGE_COUNT_RST;
      ra         <= '0;
      pw         <= '0;
      rvalid     <= 1'b0;
      fail       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          fpa_pkg::CFG_BASE_PAGE:  base_page  <= cfg_wdata[fpa_pkg::BASE_PAGE_W-1:0];
          fpa_pkg::CFG_PAGE_COUNT: page_count <= cfg_wdata[fpa_pkg::PAGE_COUNT_W-1:0];
          default: ;
        endcase
      end

      // result word taken, unless a new one is loaded in its place
      if (out_valid && resp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        // zero the used map one word a cycle
        S_CLEAR: begin
          if (ra == LAST_WORD) begin
            ra    <= '0;
            state <= S_IDLE;
          end else begin
            ra <= AW'(ra + 1'b1);
          end
        end
        // take a request word
        S_IDLE: begin
          if (req.valid) begin
            want   <= LW'(req.want_pages);
            run    <= '0;
            ra     <= '0;
            pw     <= '0;
            rvalid <= 1'b0;
            if ((req.want_pages == '0) || (LW'(req.want_pages) > limit)) begin
              fail  <= 1'b1;
              state <= S_FIN;
            end else begin
              fail  <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        // stream words in and track the free run
        S_SCAN: begin
          rvalid <= 1'b1;
          if (ra != LAST_WORD) begin
            ra <= AW'(ra + 1'b1);
          end
          if (rvalid) begin
            run <= run_next;
            pw  <= AW'(pw + 1'b1);
            if (scan_res.found) begin
              end_idx <= {pw, scan_res.hit};
              state   <= S_CALC;
            end else if (scan_res.past_end) begin
              fail  <= 1'b1;
              state <= S_FIN;
            end
          end
        end
        // locate the run's first page
        S_CALC: begin
          start  <= start_next;
          ra     <= start_next[XW-1:fpa_pkg::BIT_W];
          pw     <= start_next[XW-1:fpa_pkg::BIT_W];
          rvalid <= 1'b0;
          state  <= S_MARK;
        end
        // read, set and write back each word of the run
        S_MARK: begin
          rvalid <= 1'b1;
          phys   <= prod;
          if (ra != LAST_WORD) begin
            ra <= AW'(ra + 1'b1);
          end
          if (rvalid) begin
            if (pw == end_word) begin
              state <= S_FIN;
            end else begin
              pw <= AW'(pw + 1'b1);
            end
          end
        end
        // load the result register once it is free
        S_FIN: begin
          if (!out_valid || resp.ready) begin
            out_valid  <= 1'b1;
            out_addr   <= fail ? '0 : phys;
            out_status <= fail ? fpa_pkg::STATUS_NOSPACE : fpa_pkg::STATUS_GRANT;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `FPA_ASSERT_NOW(a_fail_addr_zero, clk, rst, resp.valid && (resp.status == fpa_pkg::STATUS_NOSPACE), resp.phys_addr == '0)
  `FPA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `FPA_ASSERT_NOW(a_mark_in_run, clk, rst, ram_we && (state == S_MARK), (pw >= start_word) && (pw <= end_word))
  `FPA_ASSERT_NOW(a_run_fits, clk, rst, state == S_CALC, (CMPW'(end_idx) + 1'b1) >= CMPW'(want))

endmodule
`default_nettype wire
